>>> hw/rtl/gemg_pkg.sv
// ----------------------------------------------------------------------------
// gemg_pkg
// Shared widths, configuration record and the command and status bundles
// that pass between the galvo ease-move controller and its datapath.
// ----------------------------------------------------------------------------
package gemg_pkg;

   // Position format: signed Q10.8.
   localparam int POS_W         = 18;
   localparam int POS_FRAC_BITS = 8;
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   localparam int GAIN_W   = 8;
   localparam int DIVR_W   = 8;
   localparam int DIST_W   = 16;
   localparam int DUTY_W   = 8;
   localparam int WDIV_W   = 16;

   // Distance to target and the step quotient (distance times 16 over the divisor).
   localparam int DIFF_W   = POS_W + 1;
   localparam int MAG_W    = POS_W;
   localparam int QUO_W    = MAG_W + 4;
   localparam int DCNT_W   = $clog2(QUO_W);

   localparam int MAX_STEPS = 63;
   localparam int STEP_W    = 6;

   // Full duty span of the position window, in whole position units.
   localparam int DUTY_SPAN = 255;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_APPROACH_DIVISOR = 3'd0,
      CSR_SNAP_DISTANCE    = 3'd1,
      CSR_STEP_LIMIT       = 3'd2,
      CSR_RELATIVE_GAIN    = 3'd3,
      CSR_X_WINDOW_LOW     = 3'd4,
      CSR_X_WINDOW_HIGH    = 3'd5,
      CSR_Y_WINDOW_LOW     = 3'd6,
      CSR_Y_WINDOW_HIGH    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [DIVR_W-1:0] approach_divisor;
      logic [DIST_W-1:0] snap_distance;
      logic [DIST_W-1:0] step_limit;
      logic [GAIN_W-1:0] relative_gain;
      logic [DUTY_W-1:0] x_window_low;
      logic [DUTY_W-1:0] x_window_high;
      logic [DUTY_W-1:0] y_window_low;
      logic [DUTY_W-1:0] y_window_high;
   } cfg_type;

   typedef struct packed {
      logic load_in;    // capture the request and scale the delta
      logic load_goal;  // settle the target, restart divisor and step count
      logic div_start;  // load the dividers with the remaining distance
      logic div_step;   // one quotient bit on each axis
      logic halve;      // halve both steps, grow the divisor
      logic update;     // move the position by the step
      logic snap;       // position takes the target, marks the final point
      logic duty_mul;   // register the window products
      logic out_load;   // load the result register
   } cmd_type;

   typedef struct packed {
      logic far;        // an axis is farther than the snap distance
      logic cap;        // step count at its limit
      logic div_last;   // the division is on its last bit
      logic too_big;    // a step is above the step limit
      logic final_pt;   // the pending result ends the move
   } status_type;

endpackage

>>> hw/rtl/gemg_csr.sv
// ----------------------------------------------------------------------------
// gemg_csr
// Configuration registers of the ease-move generator, written through a
// valid/ready port by register index.
// ----------------------------------------------------------------------------
module gemg_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gemg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gemg_pkg::CSR_DATA_W-1:0]    csr_data,
   output gemg_pkg::cfg_type                  cfg
);

   gemg_pkg::cfg_type cfg_ff;
   gemg_pkg::cfg_type cfg_in;

   localparam gemg_pkg::cfg_type CFG_RESET = '{
      approach_divisor : 8'd43,
      snap_distance    : 16'd128,
      step_limit       : 16'd7680,
      relative_gain    : 8'd38,
      x_window_low     : 8'd5,
      x_window_high    : 8'd190,
      y_window_low     : 8'd5,
      y_window_high    : 8'd190
   };

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (gemg_pkg::csr_index_type'(csr_index))
            gemg_pkg::CSR_APPROACH_DIVISOR: begin
               cfg_in.approach_divisor = csr_data[gemg_pkg::DIVR_W-1:0];
            end
            gemg_pkg::CSR_SNAP_DISTANCE: begin
               cfg_in.snap_distance = csr_data[gemg_pkg::DIST_W-1:0];
            end
            gemg_pkg::CSR_STEP_LIMIT: begin
               cfg_in.step_limit = csr_data[gemg_pkg::DIST_W-1:0];
            end
            gemg_pkg::CSR_RELATIVE_GAIN: begin
               cfg_in.relative_gain = csr_data[gemg_pkg::GAIN_W-1:0];
            end
            gemg_pkg::CSR_X_WINDOW_LOW: begin
               cfg_in.x_window_low = csr_data[gemg_pkg::DUTY_W-1:0];
            end
            gemg_pkg::CSR_X_WINDOW_HIGH: begin
               cfg_in.x_window_high = csr_data[gemg_pkg::DUTY_W-1:0];
            end
            gemg_pkg::CSR_Y_WINDOW_LOW: begin
               cfg_in.y_window_low = csr_data[gemg_pkg::DUTY_W-1:0];
            end
            gemg_pkg::CSR_Y_WINDOW_HIGH: begin
               cfg_in.y_window_high = csr_data[gemg_pkg::DUTY_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/gemg_datapath.sv
// ----------------------------------------------------------------------------
// gemg_datapath
// Position and target registers, the two-lane restoring divider for the
// easing step, the halving unit and the duty mapping for both axes.
// ----------------------------------------------------------------------------
module gemg_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  gemg_pkg::cfg_type                       cfg,
   input  gemg_pkg::cmd_type                       cmd,
   output gemg_pkg::status_type                    status,
   input  logic                                    req_kind,
   input  logic signed [gemg_pkg::POS_W-1:0]       req_x_value,
   input  logic signed [gemg_pkg::POS_W-1:0]       req_y_value,
   output logic [gemg_pkg::DUTY_W-1:0]             rsp_x_duty,
   output logic [gemg_pkg::DUTY_W-1:0]             rsp_y_duty,
   output logic                                    rsp_final_point
);

   localparam int POS_W  = gemg_pkg::POS_W;
   localparam int DIFF_W = gemg_pkg::DIFF_W;
   localparam int MAG_W  = gemg_pkg::MAG_W;
   localparam int QUO_W  = gemg_pkg::QUO_W;
   localparam int DCNT_W = gemg_pkg::DCNT_W;
   localparam int WDIV_W = gemg_pkg::WDIV_W;
   localparam int DIST_W = gemg_pkg::DIST_W;
   localparam int DUTY_W = gemg_pkg::DUTY_W;
   localparam int STEP_W = gemg_pkg::STEP_W;
   localparam int PRD_W  = POS_W + gemg_pkg::GAIN_W + 1;
   localparam int SAT_W  = PRD_W + 1;
   localparam int SPN_W  = DUTY_W + 1;
   localparam int DPRD_W = POS_W + SPN_W;
   localparam int T_W    = DPRD_W - gemg_pkg::POS_FRAC_BITS + 2;
   localparam int U_W    = T_W - 1;
   localparam int LO_W   = 2 * DUTY_W;
   localparam logic [U_W-1:0] U_LOW  = U_W'(gemg_pkg::DUTY_SPAN);
   localparam logic [U_W-1:0] U_HIGH = U_W'(gemg_pkg::DUTY_SPAN * 256);

   // Truncation toward zero of a division by 16 (bias negatives by 15).
   function automatic logic signed [PRD_W-1:0] div16_tz(input logic signed [PRD_W-1:0] v);
      logic signed [PRD_W-1:0] b;
      b = v + {{(PRD_W-4){1'b0}}, {4{v[PRD_W-1]}}};
      return b >>> 4;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi_lim;
      logic signed [SAT_W-1:0] lo_lim;
      hi_lim = SAT_W'(gemg_pkg::POS_MAX);
      lo_lim = SAT_W'(gemg_pkg::POS_MIN);
      if (v > hi_lim) begin
         return gemg_pkg::POS_MAX;
      end
      if (v < lo_lim) begin
         return gemg_pkg::POS_MIN;
      end
      return v[POS_W-1:0];
   endfunction

   // floor((lo*255*2^F + pos*(hi-lo)) / (255*2^F)), clamped to 1..hi.
   // The division by 255 takes the quotient by 256 and corrects it by one.
   function automatic logic [DUTY_W-1:0] duty_of(input logic signed [DPRD_W-1:0] p,
                                                 input logic [DUTY_W-1:0] lo,
                                                 input logic [DUTY_W-1:0] hi);
      logic [LO_W-1:0]         lo255;
      logic signed [T_W-1:0]   t;
      logic [U_W-1:0]          u;
      logic [15:0]             x;
      logic [7:0]              q0;
      logic [15:0]             r;
      logic [DUTY_W:0]         v;
      lo255 = {lo, 8'h00} - {8'h00, lo};
      t = T_W'(p >>> gemg_pkg::POS_FRAC_BITS) + T_W'({1'b0, lo255});
      u = t[U_W-1:0];
      x = u[15:0];
      q0 = x[15:8];
      r = x - ({q0, 8'h00} - {8'h00, q0});
      if (t[T_W-1] || (u < U_LOW)) begin
         v = (DUTY_W+1)'(1);
      end else if (u >= U_HIGH) begin
         v = {1'b1, {DUTY_W{1'b0}}};
      end else begin
         v = {1'b0, q0} + (DUTY_W+1)'(r >= 16'(gemg_pkg::DUTY_SPAN));
      end
      if (v > {1'b0, hi}) begin
         return hi;
      end
      return v[DUTY_W-1:0];
   endfunction

   // Control and architectural state.
   logic signed [POS_W-1:0]  x_pos_ff, x_pos_in, y_pos_ff, y_pos_in;
   logic signed [POS_W-1:0]  x_goal_ff, x_goal_in, y_goal_ff, y_goal_in;
   logic [WDIV_W-1:0]        wdiv_ff, wdiv_in;
   logic [STEP_W-1:0]        steps_ff, steps_in;
   logic [DCNT_W-1:0]        cnt_ff, cnt_in;
   logic                     fin_ff, fin_in;

   // Working payload.
   logic                     kind_ff, kind_in;
   logic signed [POS_W-1:0]  x_raw_ff, x_raw_in, y_raw_ff, y_raw_in;
   logic signed [PRD_W-1:0]  x_scl_ff, x_scl_in, y_scl_ff, y_scl_in;
   logic [QUO_W-1:0]         x_dvd_ff, x_dvd_in, y_dvd_ff, y_dvd_in;
   logic [WDIV_W-1:0]        x_rem_ff, x_rem_in, y_rem_ff, y_rem_in;
   logic                     x_neg_ff, x_neg_in, y_neg_ff, y_neg_in;
   logic signed [DPRD_W-1:0] x_dprd_ff, x_dprd_in, y_dprd_ff, y_dprd_in;
   logic [DUTY_W-1:0]        x_duty_ff, x_duty_in, y_duty_ff, y_duty_in;
   logic                     final_ff, final_in;

   logic signed [PRD_W-1:0]  x_prd, y_prd;
   logic signed [SAT_W-1:0]  x_gsum, y_gsum, x_usum, y_usum;
   logic signed [DIFF_W-1:0] x_diff, y_diff;
   logic [MAG_W-1:0]         x_mag, y_mag;
   logic [WDIV_W:0]          x_rsh, y_rsh, wdiv_ext, wdiv_grow;
   logic                     x_ge, y_ge;
   logic signed [DIST_W:0]   x_stp, y_stp;
   logic signed [SPN_W-1:0]  x_span, y_span;

   assign x_prd = PRD_W'(req_x_value) * PRD_W'($signed({1'b0, cfg.relative_gain}));
   assign y_prd = PRD_W'(req_y_value) * PRD_W'($signed({1'b0, cfg.relative_gain}));

   assign x_gsum = SAT_W'(x_pos_ff) + SAT_W'(x_scl_ff);
   assign y_gsum = SAT_W'(y_pos_ff) + SAT_W'(y_scl_ff);

   assign x_diff = DIFF_W'(x_goal_ff) - DIFF_W'(x_pos_ff);
   assign y_diff = DIFF_W'(y_goal_ff) - DIFF_W'(y_pos_ff);
   assign x_mag  = x_diff[DIFF_W-1] ? MAG_W'(-x_diff) : x_diff[MAG_W-1:0];
   assign y_mag  = y_diff[DIFF_W-1] ? MAG_W'(-y_diff) : y_diff[MAG_W-1:0];

   assign wdiv_ext = {1'b0, wdiv_ff};
   assign x_rsh = {x_rem_ff, x_dvd_ff[QUO_W-1]};
   assign y_rsh = {y_rem_ff, y_dvd_ff[QUO_W-1]};
   assign x_ge  = x_rsh >= wdiv_ext;
   assign y_ge  = y_rsh >= wdiv_ext;

   assign wdiv_grow = wdiv_ext + {2'b00, wdiv_ff[WDIV_W-1:1]};

   // Once the halving is through, each step fits the step limit width.
   assign x_stp = x_neg_ff ? -$signed({1'b0, x_dvd_ff[DIST_W-1:0]})
                           :  $signed({1'b0, x_dvd_ff[DIST_W-1:0]});
   assign y_stp = y_neg_ff ? -$signed({1'b0, y_dvd_ff[DIST_W-1:0]})
                           :  $signed({1'b0, y_dvd_ff[DIST_W-1:0]});
   assign x_usum = SAT_W'(x_pos_ff) + SAT_W'(x_stp);
   assign y_usum = SAT_W'(y_pos_ff) + SAT_W'(y_stp);

   assign x_span = $signed({1'b0, cfg.x_window_high}) - $signed({1'b0, cfg.x_window_low});
   assign y_span = $signed({1'b0, cfg.y_window_high}) - $signed({1'b0, cfg.y_window_low});

   always_comb begin
      x_pos_in  = x_pos_ff;
      y_pos_in  = y_pos_ff;
      x_goal_in = x_goal_ff;
      y_goal_in = y_goal_ff;
      wdiv_in   = wdiv_ff;
      steps_in  = steps_ff;
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      kind_in   = kind_ff;
      x_raw_in  = x_raw_ff;
      y_raw_in  = y_raw_ff;
      x_scl_in  = x_scl_ff;
      y_scl_in  = y_scl_ff;
      x_dvd_in  = x_dvd_ff;
      y_dvd_in  = y_dvd_ff;
      x_rem_in  = x_rem_ff;
      y_rem_in  = y_rem_ff;
      x_neg_in  = x_neg_ff;
      y_neg_in  = y_neg_ff;
      x_dprd_in = x_dprd_ff;
      y_dprd_in = y_dprd_ff;
      x_duty_in = x_duty_ff;
      y_duty_in = y_duty_ff;
      final_in  = final_ff;

      if (cmd.load_in) begin
         kind_in  = req_kind;
         x_raw_in = req_x_value;
         y_raw_in = req_y_value;
         x_scl_in = div16_tz(x_prd);
         y_scl_in = div16_tz(y_prd);
      end

      if (cmd.load_goal) begin
         x_goal_in = kind_ff ? sat_pos(x_gsum) : x_raw_ff;
         y_goal_in = kind_ff ? sat_pos(y_gsum) : y_raw_ff;
         wdiv_in   = (cfg.approach_divisor != '0) ? WDIV_W'(cfg.approach_divisor)
                                                  : WDIV_W'(1);
         steps_in  = '0;
         fin_in    = 1'b0;
      end

      if (cmd.div_start) begin
         x_dvd_in = {x_mag, 4'h0};
         y_dvd_in = {y_mag, 4'h0};
         x_rem_in = '0;
         y_rem_in = '0;
         x_neg_in = x_diff[DIFF_W-1];
         y_neg_in = y_diff[DIFF_W-1];
         cnt_in   = '0;
      end

      if (cmd.div_step) begin
         x_rem_in = x_ge ? WDIV_W'(x_rsh - wdiv_ext) : x_rsh[WDIV_W-1:0];
         y_rem_in = y_ge ? WDIV_W'(y_rsh - wdiv_ext) : y_rsh[WDIV_W-1:0];
         x_dvd_in = {x_dvd_ff[QUO_W-2:0], x_ge};
         y_dvd_in = {y_dvd_ff[QUO_W-2:0], y_ge};
         cnt_in   = cnt_ff + DCNT_W'(1);
      end

      if (cmd.halve) begin
         x_dvd_in = x_dvd_ff >> 1;
         y_dvd_in = y_dvd_ff >> 1;
         wdiv_in  = wdiv_grow[WDIV_W] ? {WDIV_W{1'b1}} : wdiv_grow[WDIV_W-1:0];
      end

      if (cmd.update) begin
         x_pos_in = sat_pos(x_usum);
         y_pos_in = sat_pos(y_usum);
         steps_in = steps_ff + STEP_W'(1);
      end

      if (cmd.snap) begin
         x_pos_in = x_goal_ff;
         y_pos_in = y_goal_ff;
         fin_in   = 1'b1;
      end

      if (cmd.duty_mul) begin
         x_dprd_in = DPRD_W'(x_pos_ff) * DPRD_W'(x_span);
         y_dprd_in = DPRD_W'(y_pos_ff) * DPRD_W'(y_span);
      end

      if (cmd.out_load) begin
         x_duty_in = duty_of(x_dprd_ff, cfg.x_window_low, cfg.x_window_high);
         y_duty_in = duty_of(y_dprd_ff, cfg.y_window_low, cfg.y_window_high);
         final_in  = fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_pos_ff  <= '0;
         y_pos_ff  <= '0;
         x_goal_ff <= '0;
         y_goal_ff <= '0;
         wdiv_ff   <= '0;
         steps_ff  <= '0;
         cnt_ff    <= '0;
         fin_ff    <= 1'b0;
      end else begin
         x_pos_ff  <= x_pos_in;
         y_pos_ff  <= y_pos_in;
         x_goal_ff <= x_goal_in;
         y_goal_ff <= y_goal_in;
         wdiv_ff   <= wdiv_in;
         steps_ff  <= steps_in;
         cnt_ff    <= cnt_in;
         fin_ff    <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      x_raw_ff  <= x_raw_in;
      y_raw_ff  <= y_raw_in;
      x_scl_ff  <= x_scl_in;
      y_scl_ff  <= y_scl_in;
      x_dvd_ff  <= x_dvd_in;
      y_dvd_ff  <= y_dvd_in;
      x_rem_ff  <= x_rem_in;
      y_rem_ff  <= y_rem_in;
      x_neg_ff  <= x_neg_in;
      y_neg_ff  <= y_neg_in;
      x_dprd_ff <= x_dprd_in;
      y_dprd_ff <= y_dprd_in;
      x_duty_ff <= x_duty_in;
      y_duty_ff <= y_duty_in;
      final_ff  <= final_in;
   end

   assign status.far      = (x_mag > MAG_W'(cfg.snap_distance)) ||
                            (y_mag > MAG_W'(cfg.snap_distance));
   assign status.cap      = steps_ff == STEP_W'(gemg_pkg::MAX_STEPS);
   assign status.div_last = cnt_ff == DCNT_W'(QUO_W - 1);
   assign status.too_big  = (x_dvd_ff > QUO_W'(cfg.step_limit)) ||
                            (y_dvd_ff > QUO_W'(cfg.step_limit));
   assign status.final_pt = fin_ff;

   assign rsp_x_duty      = x_duty_ff;
   assign rsp_y_duty      = y_duty_ff;
   assign rsp_final_point = final_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && status.div_last) |=> (x_rem_ff < wdiv_ff) && (y_rem_ff < wdiv_ff))
      else $error("divider remainder not below the divisor");

   a_divisor_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.halve |=> (wdiv_ff >= $past(wdiv_ff)))
      else $error("working divisor shrank on a halving");

   a_start_below_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (status.far && !status.cap))
      else $error("step started at the cap or within snap distance");

   a_snap_reaches_goal: assert property (@(posedge clock) disable iff (reset)
      cmd.snap |=> (x_pos_ff == x_goal_ff) && (y_pos_ff == y_goal_ff) && fin_ff)
      else $error("snap did not land on the target");
`endif

endmodule

>>> hw/rtl/gemg_ctrl.sv
// ----------------------------------------------------------------------------
// gemg_ctrl
// Sequencer of the ease move: takes a request, runs divide, halve and
// update for each step, and hands every result to the output register.
// ----------------------------------------------------------------------------
module gemg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  gemg_pkg::status_type  status,
   output gemg_pkg::cmd_type     cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_GOAL  = 7'b0000010,
      ST_CHECK = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_HALVE = 7'b0010000,
      ST_MUL   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_GOAL;
            end
         end
         ST_GOAL: begin
            cmd.load_goal = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.far && !status.cap) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.snap = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_HALVE;
            end
         end
         ST_HALVE: begin
            // One halving per cycle until both steps fit the limit.
            if (status.too_big) begin
               cmd.halve = 1'b1;
            end else begin
               cmd.update = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.duty_mul = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = status.final_pt ? ST_IDLE : ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");

   a_final_ends_move: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free && status.final_pt) |=>
         (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("final result did not end the move");

   a_halve_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HALVE && !status.too_big) |=> (state_ff == ST_MUL))
      else $error("step within limit did not move on to the duty stage");
`endif

endmodule

>>> hw/rtl/galvo_ease_move_generator.sv
// Each accepted move loads the request and target; each easing step divides, halves
// (0 to 22 halvings), updates and emits a result; a snap result ends the move.
// The bit-serial divider of each step sets the rate; up to 64 results a move.
// One move at a time: the next request is taken once the final result is registered.
// Synchronous reset clears position, target and divisor and loads register defaults.
// ----------------------------------------------------------------------------
// galvo_ease_move_generator
// Exponential-ease motion generator for a two-axis beam: steps the stored
// position toward each requested target and emits a PWM duty pair per step.
// ----------------------------------------------------------------------------
module galvo_ease_move_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic signed [gemg_pkg::POS_W-1:0]     req_x_value,
   input  logic signed [gemg_pkg::POS_W-1:0]     req_y_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [gemg_pkg::DUTY_W-1:0]           rsp_x_duty,
   output logic [gemg_pkg::DUTY_W-1:0]           rsp_y_duty,
   output logic                                  rsp_final_point,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gemg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gemg_pkg::CSR_DATA_W-1:0]       csr_data
);

   gemg_pkg::cfg_type    cfg;
   gemg_pkg::cmd_type    cmd;
   gemg_pkg::status_type status;

   gemg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gemg_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .rsp_x_duty      (rsp_x_duty),
      .rsp_y_duty      (rsp_y_duty),
      .rsp_final_point (rsp_final_point)
   );

   gemg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

endmodule
